@@ hw/rtl/delimited_field_number_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// Delimited field number parser: assertion macros
// Concurrent assertion helpers shared by the parser RTL. They expand to
// nothing when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FIELD_NUMBER_PARSER_TOP_DEFINES_SVH
`define DELIMITED_FIELD_NUMBER_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define DFNP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DFNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DFNP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`define DFNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/dfnp_pkg.sv @@
// ----------------------------------------------------------------------------
// dfnp_pkg
// Types, character codes and helpers for the delimited field number parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dfnp_pkg;

    localparam int CH_W    = 16;
    localparam int VALUE_W = 32;
    localparam int KEEP_W  = 5;

    localparam int DEF_SHORT_KEEP = 9;
    localparam int DEF_LONG_KEEP  = 19;
    localparam int DEF_ADDR_KEEP  = 8;

    localparam logic [CH_W-1:0] DELIM_RESET = 16'h002C;
    localparam logic [CH_W-1:0] CH_NUL      = 16'h0000;
    localparam logic [CH_W-1:0] CH_TAB      = 16'h0009;
    localparam logic [CH_W-1:0] CH_LF       = 16'h000A;
    localparam logic [CH_W-1:0] CH_CR       = 16'h000D;
    localparam logic [CH_W-1:0] CH_SPACE    = 16'h0020;
    localparam logic [CH_W-1:0] CH_PLUS     = 16'h002B;
    localparam logic [CH_W-1:0] CH_MINUS    = 16'h002D;
    localparam logic [CH_W-1:0] CH_ZERO     = 16'h0030;
    localparam logic [CH_W-1:0] CH_NINE     = 16'h0039;
    localparam logic [CH_W-1:0] CH_UPPER_A  = 16'h0041;
    localparam logic [CH_W-1:0] CH_UPPER_F  = 16'h0046;
    localparam logic [CH_W-1:0] CH_LOWER_A  = 16'h0061;
    localparam logic [CH_W-1:0] CH_LOWER_F  = 16'h0066;

    // Position of the hex nibble in an address field.
    localparam logic [KEEP_W-1:0] ADDR_NIBBLE_POS = 5'd3;

    typedef enum logic [1:0] {
        MODE_DEC_SHORT = 2'd0,
        MODE_DEC_LONG  = 2'd1,
        MODE_HEX       = 2'd2,
        MODE_ADDR      = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_SIGN   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2,
        PH_VOID   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [KEEP_W-1:0]  kept;
        t_phase             phase;
        logic               negative;
        logic [3:0]         nibble;
        t_mode              mode;
        logic               dropped;
    } t_field_state;

    localparam t_field_state FIELD_CLEAR = '{
        acc:      '0,
        kept:     '0,
        phase:    PH_SIGN,
        negative: 1'b0,
        nibble:   4'd0,
        mode:     MODE_DEC_SHORT,
        dropped:  1'b0
    };

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               field_empty;
        logic               chars_dropped;
    } t_result;

    function automatic logic [KEEP_W-1:0] keep_limit(
        input t_mode             mode,
        input logic [KEEP_W-1:0] short_keep,
        input logic [KEEP_W-1:0] long_keep,
        input logic [KEEP_W-1:0] addr_keep
    );
        logic [KEEP_W-1:0] lim;
        unique case (mode)
            MODE_DEC_LONG: lim = long_keep;
            MODE_ADDR:     lim = addr_keep;
            default:       lim = short_keep;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dfnp_in_if.sv @@
// ----------------------------------------------------------------------------
// dfnp_in_if
// Character channel into the parser: one text character per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfnp_in_if
    import dfnp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            line_end;
    logic [1:0]      conv_mode;

    modport source (output valid, output ch, output line_end, output conv_mode,
                    input ready);
    modport sink   (input valid, input ch, input line_end, input conv_mode,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dfnp_out_if.sv @@
// ----------------------------------------------------------------------------
// dfnp_out_if
// Result channel of the parser: one converted number per field.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfnp_out_if
    import dfnp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               field_empty;
    logic               chars_dropped;

    modport source (output valid, output value, output field_empty,
                    output chars_dropped, input ready);
    modport sink   (input valid, input value, input field_empty,
                    input chars_dropped, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dfnp_step.sv @@
// ----------------------------------------------------------------------------
// dfnp_step
// Per-character field update: classifies one character, advances the field
// state and forms the result when the field closes.
// ----------------------------------------------------------------------------
`default_nettype none

module dfnp_step
    import dfnp_pkg::*;
#(
    parameter int SHORT_KEEP = DEF_SHORT_KEEP,
    parameter int LONG_KEEP  = DEF_LONG_KEEP,
    parameter int ADDR_KEEP  = DEF_ADDR_KEEP
) (
    input  t_field_state    i_state,
    input  logic [CH_W-1:0] i_ch,
    input  logic            i_line_end,
    input  logic [1:0]      i_conv_mode,
    input  logic [CH_W-1:0] i_delimiter,
    output t_field_state    o_state,
    output logic            o_emit,
    output t_result         o_result
);

    logic               is_digit;
    logic               is_upper_hex;
    logic               is_lower_hex;
    logic               is_space;
    logic               end_char;
    logic [3:0]         nib_upper;
    logic [3:0]         nib_any;
    logic [KEEP_W-1:0]  lim;
    logic               blank;
    logic               fin;
    t_field_state       s;
    logic [VALUE_W-1:0] signed_val;

    assign is_digit     = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_upper_hex = (i_ch >= CH_UPPER_A) && (i_ch <= CH_UPPER_F);
    assign is_lower_hex = (i_ch >= CH_LOWER_A) && (i_ch <= CH_LOWER_F);
    assign is_space     = ((i_ch >= CH_TAB) && (i_ch <= CH_CR)) || (i_ch == CH_SPACE);
    assign end_char     = (i_ch == i_delimiter) || (i_ch == CH_LF) || (i_ch == CH_CR);

    // Letters sit at code 0x41 or 0x61, so the low nibble plus nine is the value.
    assign nib_upper = is_digit ? i_ch[3:0] : (is_upper_hex ? i_ch[3:0] + 4'd9 : 4'd0);
    assign nib_any   = is_lower_hex ? i_ch[3:0] + 4'd9 : nib_upper;

    always_comb begin
        s     = i_state;
        fin   = 1'b0;
        lim   = '0;
        blank = 1'b0;
        if (end_char) begin
            fin = 1'b1;
        end else begin
            if (s.kept == '0) begin
                s.mode = t_mode'(i_conv_mode);
            end
            lim   = keep_limit(s.mode, KEEP_W'(SHORT_KEEP), KEEP_W'(LONG_KEEP),
                               KEEP_W'(ADDR_KEEP));
            blank = (s.kept == '0) && ((i_ch == CH_SPACE) || (i_ch == CH_TAB));
            if (!blank) begin
                if (s.kept < lim) begin
                    if ((s.mode == MODE_ADDR) && (s.kept == ADDR_NIBBLE_POS)
                        && (s.phase != PH_VOID)) begin
                        s.nibble = nib_upper;
                    end
                    if ((s.phase == PH_SIGN) || (s.phase == PH_DIGITS)) begin
                        if (i_ch == CH_NUL) begin
                            s.phase = (s.kept == '0) ? PH_VOID : PH_DONE;
                        end else if (s.mode == MODE_HEX) begin
                            s.acc = {s.acc[VALUE_W-5:0], nib_any};
                        end else if ((s.mode != MODE_ADDR) || (s.kept < ADDR_NIBBLE_POS)) begin
                            if (s.phase == PH_SIGN) begin
                                if (!is_space) begin
                                    priority if (i_ch == CH_PLUS) begin
                                        s.phase = PH_DIGITS;
                                    end else if (i_ch == CH_MINUS) begin
                                        s.negative = 1'b1;
                                        s.phase    = PH_DIGITS;
                                    end else if (is_digit) begin
                                        s.acc   = VALUE_W'(i_ch[3:0]);
                                        s.phase = PH_DIGITS;
                                    end else begin
                                        s.phase = PH_DONE;
                                    end
                                end
                            end else if (is_digit) begin
                                s.acc = (s.acc << 3) + (s.acc << 1) + VALUE_W'(i_ch[3:0]);
                            end else begin
                                s.phase = PH_DONE;
                            end
                        end
                    end
                    s.kept = s.kept + 1'b1;
                end else begin
                    s.dropped = 1'b1;
                end
            end
            if (i_line_end) begin
                fin = 1'b1;
            end
        end
    end

    assign signed_val = s.negative ? (~s.acc + 1'b1) : s.acc;

    always_comb begin
        if ((s.kept == '0) || (s.phase == PH_VOID)) begin
            o_result.value = '0;
        end else begin
            unique case (s.mode)
                MODE_HEX:  o_result.value = s.acc;
                MODE_ADDR: o_result.value = {16'd0, signed_val[11:0], s.nibble};
                default:   o_result.value = signed_val;
            endcase
        end
        o_result.field_empty   = (s.kept == '0);
        o_result.chars_dropped = s.dropped;
    end

    assign o_emit  = fin;
    assign o_state = fin ? FIELD_CLEAR : s;

endmodule

`default_nettype wire

@@ hw/rtl/delimited_field_number_parser_top.sv @@
// ----------------------------------------------------------------------------
// delimited_field_number_parser_top
// Cuts a character stream into delimited fields and converts each field to
// a 32-bit number (decimal, hex or address form).
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake     Contents
//  i_in      in         valid/ready   ch, line_end, conv_mode
//  o_out     out        valid/ready   value, field_empty, chars_dropped
//  i_cfg_*   in         write enable  delimiter code, 16 bits
//
// One item is taken in every clock cycle unless the output stalls; the rate
// is set by the single field update step between the input register and
// the result register. An item that closes a field goes into the input
// register, and its result is then loaded into the result register.
// After reset the delimiter is a comma and every field starts empty.
// When the result register is full and not taken, the input register holds
// its item and the input stops taking new ones until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delimited_field_number_parser_top_defines.svh"

module delimited_field_number_parser_top
    import dfnp_pkg::*;
#(
    parameter int SHORT_KEEP = DEF_SHORT_KEEP,
    parameter int LONG_KEEP  = DEF_LONG_KEEP,
    parameter int ADDR_KEEP  = DEF_ADDR_KEEP
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dfnp_in_if.sink         i_in,
    dfnp_out_if.source      o_out,
    input  logic            i_cfg_we,
    input  logic [CH_W-1:0] i_cfg_data
);

    // Input register: one character item waiting for the field update.
    logic            r_in_valid;
    logic [CH_W-1:0] r_in_ch;
    logic            r_in_line_end;
    logic [1:0]      r_in_conv_mode;

    // Field state carried between characters, and the delimiter register.
    t_field_state    r_state;
    t_field_state    n_state;
    logic [CH_W-1:0] r_delimiter;

    // Result register feeding the output channel.
    logic            r_out_valid;
    t_result         r_out;
    t_result         n_out;
    logic            w_emit;

    logic            w_advance;
    logic            w_take_in;
    logic [KEEP_W-1:0] w_limit;

    // The held character moves on when the result register can accept
    // whatever it may produce; this keeps the state update in step.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_take_in  = i_in.valid && i_in.ready;

    dfnp_step #(
        .SHORT_KEEP (SHORT_KEEP),
        .LONG_KEEP  (LONG_KEEP),
        .ADDR_KEEP  (ADDR_KEEP)
    ) u_step (
        .i_state     (r_state),
        .i_ch        (r_in_ch),
        .i_line_end  (r_in_line_end),
        .i_conv_mode (r_in_conv_mode),
        .i_delimiter (r_delimiter),
        .o_state     (n_state),
        .o_emit      (w_emit),
        .o_result    (n_out)
    );

    // Control state and the delimiter register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= FIELD_CLEAR;
            r_delimiter <= DELIM_RESET;
        end else begin
            if (i_cfg_we) begin
                r_delimiter <= i_cfg_data;
            end
            if (w_take_in) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_in_ch        <= i_in.ch;
            r_in_line_end  <= i_in.line_end;
            r_in_conv_mode <= i_in.conv_mode;
        end
        if (w_advance && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.value         = r_out.value;
    assign o_out.field_empty   = r_out.field_empty;
    assign o_out.chars_dropped = r_out.chars_dropped;

    // Keep limit of the current field, used by the checks below.
    assign w_limit = keep_limit(r_state.mode, KEEP_W'(SHORT_KEEP), KEEP_W'(LONG_KEEP),
                                KEEP_W'(ADDR_KEEP));

    // An empty field always reports the value zero.
    `DFNP_ASSERT_SAME(a_empty_is_zero, i_clk, i_rst_n, o_out.valid && o_out.field_empty, o_out.value == '0, "empty field gave a nonzero value")

    // The kept count never passes the limit of the field's mode.
    `DFNP_ASSERT_SAME(a_kept_in_limit, i_clk, i_rst_n, r_state.kept != '0, r_state.kept <= w_limit, "kept count beyond keep limit")

    // A stalled result holds the waiting character in the input register.
    `DFNP_ASSERT_NEXT(a_input_held, i_clk, i_rst_n, r_in_valid && r_out_valid && !o_out.ready, r_in_valid, "input item lost under output stall")

endmodule

`default_nettype wire

@@ tb/delimited_field_number_parser_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delimited field number parser: self-checking testbench
// Feeds character items into the parser, predicts every field result from
// its own model of the field state and compares the results as they drain.
// The delimiter register is rewritten between phases of traffic.
// ----------------------------------------------------------------------------

module delimited_field_number_parser_top_tb;
    import dfnp_pkg::*;

    // Run sizing. About 1750 character items in all, spread over the phases.
    localparam int ITEMS_PER_PHASE = 215;
    localparam int SETTLE_CYCLES   = 6;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int HOLD_AFTER      = 500;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_BACKLOG    = 40;

    // One character item as the sender presents it.
    typedef struct {
        logic [CH_W-1:0] ch;
        logic            line_end;
        t_mode           mode;
    } t_char_item;

    // Flavours of random field text.
    typedef enum int {
        STYLE_NUMBER,
        STYLE_HEX,
        STYLE_ASCII,
        STYLE_WIDE,
        STYLE_NUL,
        STYLE_ADDR
    } t_text_style;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [CH_W-1:0] cfg_data;

    dfnp_in_if  char_if ();
    dfnp_out_if num_if ();

    delimited_field_number_parser_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (char_if),
        .o_out      (num_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Characters waiting to be sent, and field results waiting to arrive.
    t_char_item char_queue[$];
    t_result    field_results_q[$];

    int items_queued   = 0;
    int accepted_items = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    bit in_taken       = 1'b0;

    // Sender burst shaping, receiver stall pattern and the long hold-off.
    int burst_left = 0;
    int gap_left   = 0;
    int rx_left    = 0;
    int rx_style   = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    // Predicted state of the field being assembled inside the block.
    logic [CH_W-1:0]    delim_q;
    logic [VALUE_W-1:0] acc_q;
    logic [KEEP_W-1:0]  kept_q;
    t_phase             phase_q;
    logic               neg_q;
    logic [3:0]         nib_q;
    t_mode              fmode_q;
    logic               drop_q;

    // ------------------------------------------------------------------------
    // Clock: 20 ns period.
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Field predictor.
    // ------------------------------------------------------------------------

    // Forget everything about the current field; the delimiter survives.
    task automatic clear_field();
        acc_q   = '0;
        kept_q  = '0;
        phase_q = PH_SIGN;
        neg_q   = 1'b0;
        nib_q   = 4'd0;
        fmode_q = MODE_DEC_SHORT;
        drop_q  = 1'b0;
    endtask

    function automatic int keep_cap(input t_mode m);
        case (m)
            MODE_DEC_LONG: return DEF_LONG_KEEP;
            MODE_ADDR:     return DEF_ADDR_KEEP;
            default:       return DEF_SHORT_KEEP;
        endcase
    endfunction

    function automatic bit is_digit(input logic [CH_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Nibble of a hex character; anything that is not hex counts as zero.
    // The address nibble only accepts upper-case letters.
    function automatic logic [3:0] hex_nibble(input logic [CH_W-1:0] c,
                                              input bit lower_ok);
        if (is_digit(c))
            return c[3:0];
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            return c[3:0] + 4'd9;
        if (lower_ok && c >= CH_LOWER_A && c <= CH_LOWER_F)
            return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    // Decimal text, in the manner of atoi: blanks, a sign, then digits until
    // the first character that is not a digit.
    task automatic absorb_decimal(input logic [CH_W-1:0] c);
        case (phase_q)
            PH_SIGN: begin
                if (!((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)) begin
                    if (c == CH_PLUS) begin
                        phase_q = PH_DIGITS;
                    end else if (c == CH_MINUS) begin
                        neg_q   = 1'b1;
                        phase_q = PH_DIGITS;
                    end else if (is_digit(c)) begin
                        acc_q   = VALUE_W'(c[3:0]);
                        phase_q = PH_DIGITS;
                    end else begin
                        phase_q = PH_DONE;
                    end
                end
            end
            PH_DIGITS: begin
                if (is_digit(c))
                    acc_q = acc_q * 32'd10 + VALUE_W'(c[3:0]);
                else
                    phase_q = PH_DONE;
            end
            default: begin
            end
        endcase
    endtask

    task automatic keep_char(input logic [CH_W-1:0] c);
        // The fourth kept character of an address is read even after the
        // decimal part has stopped, but not once a leading NUL voided it.
        if (fmode_q == MODE_ADDR && kept_q == ADDR_NIBBLE_POS && phase_q != PH_VOID)
            nib_q = hex_nibble(c, 1'b0);
        if (phase_q == PH_DONE || phase_q == PH_VOID)
            return;
        if (c == CH_NUL) begin
            phase_q = (kept_q == '0) ? PH_VOID : PH_DONE;
            return;
        end
        if (fmode_q == MODE_HEX)
            acc_q = {acc_q[VALUE_W-5:0], hex_nibble(c, 1'b1)};
        else if (fmode_q != MODE_ADDR || kept_q < ADDR_NIBBLE_POS)
            absorb_decimal(c);
    endtask

    function automatic logic [VALUE_W-1:0] field_number();
        logic [VALUE_W-1:0] signed_val;
        logic [15:0]        addr;
        if (kept_q == '0 || phase_q == PH_VOID)
            return '0;
        if (fmode_q == MODE_HEX)
            return acc_q;
        signed_val = neg_q ? -acc_q : acc_q;
        if (fmode_q == MODE_ADDR) begin
            addr = 16'(signed_val * 32'd16 + VALUE_W'(nib_q));
            return {16'd0, addr};
        end
        return signed_val;
    endfunction

    // Applies one accepted character; closes says whether a result follows.
    task automatic parse_char(input t_char_item it, output bit closes,
                              output t_result res);
        closes = 1'b0;
        res    = '0;
        if (it.ch == delim_q || it.ch == CH_LF || it.ch == CH_CR) begin
            closes = 1'b1;
        end else begin
            if (kept_q == '0)
                fmode_q = it.mode;
            if (kept_q == '0 && (it.ch == CH_SPACE || it.ch == CH_TAB)) begin
                // Leading blanks are not kept.
            end else if (kept_q < keep_cap(fmode_q)) begin
                keep_char(it.ch);
                kept_q = kept_q + 1'b1;
            end else begin
                drop_q = 1'b1;
            end
            if (it.line_end)
                closes = 1'b1;
        end
        if (closes) begin
            res.value         = field_number();
            res.field_empty   = (kept_q == '0);
            res.chars_dropped = drop_q;
            clear_field();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_char(input logic [CH_W-1:0] c, input logic last,
                             input t_mode m);
        t_char_item it;
        it.ch       = c;
        it.line_end = last;
        it.mode     = m;
        char_queue.push_back(it);
        items_queued++;
    endtask

    function automatic logic [CH_W-1:0] hexish_char();
        case ($urandom_range(0, 3))
            0:       return CH_ZERO + CH_W'($urandom_range(0, 9));
            1:       return CH_UPPER_A + CH_W'($urandom_range(0, 5));
            2:       return CH_LOWER_A + CH_W'($urandom_range(0, 5));
            default: return CH_W'($urandom_range(16'h0021, 16'h007E));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_char(input t_text_style style,
                                                  input int pos);
        logic [CH_W-1:0] c;
        c = CH_ZERO + CH_W'($urandom_range(0, 9));
        case (style)
            STYLE_NUMBER: begin
                if (pos == 0 && $urandom_range(0, 2) == 0)
                    c = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
            end
            STYLE_HEX:   c = hexish_char();
            STYLE_ASCII: c = CH_W'($urandom_range(0, 127));
            STYLE_WIDE:  c = CH_W'($urandom_range(0, 65535));
            STYLE_NUL: begin
                if ($urandom_range(0, 3) == 0)
                    c = CH_NUL;
            end
            default: begin
                if (pos == 0 && $urandom_range(0, 3) == 0)
                    c = CH_MINUS;
                else if (pos == int'(ADDR_NIBBLE_POS))
                    c = hexish_char();
            end
        endcase
        return c;
    endfunction

    // One field of random text: optional leading blanks, a body whose length
    // mostly stays within the keep limit, then one of the ways a field ends.
    task automatic queue_random_field();
        t_mode       mode;
        t_text_style style;
        int          blanks;
        int          len;
        int          cap;
        int          ending;
        bit          end_on_last;
        mode   = t_mode'($urandom_range(0, 3));
        style  = t_text_style'($urandom_range(0, int'(STYLE_ADDR)));
        cap    = keep_cap(mode);
        blanks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        case ($urandom_range(0, 9))
            0:       len = 0;
            9:       len = $urandom_range(cap + 1, 24);
            default: len = $urandom_range(1, cap);
        endcase
        ending      = $urandom_range(0, 7);
        end_on_last = (ending >= 6) && (len > 0);

        // The mode is only taken while nothing is kept, so blanks carry
        // random modes and the first body character carries the real one.
        for (int i = 0; i < blanks; i++)
            push_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0,
                      t_mode'($urandom_range(0, 3)));
        for (int i = 0; i < len; i++)
            push_char(pick_char(style, i), end_on_last && (i == len - 1),
                      (i == 0 || $urandom_range(0, 7) != 0) ?
                          mode : t_mode'($urandom_range(0, 3)));
        if (!end_on_last) begin
            case (ending)
                4:       push_char(CH_CR, $urandom_range(0, 3) == 0, mode);
                5:       push_char(CH_LF, $urandom_range(0, 3) == 0, mode);
                default: push_char(delim_q, $urandom_range(0, 3) == 0, mode);
            endcase
        end
    endtask

    task automatic queue_random_phase();
        int start;
        start = items_queued;
        while (items_queued - start < ITEMS_PER_PHASE)
            queue_random_field();
    endtask

    // Waits until every queued item has gone in and every result has come
    // out, then lets the pipeline settle.
    task automatic wait_idle();
        while (char_queue.size() != 0 || char_if.valid || field_results_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The block is idle whenever this is called, so the predictor's copy of
    // the register can change at once.
    task automatic write_delimiter(input logic [CH_W-1:0] d);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = d;
        @(negedge clk);
        cfg_we   = 1'b0;
        delim_q  = d;
    endtask

    // ------------------------------------------------------------------------
    // Sender: presents queued items at the falling edge, in bursts of random
    // length separated by random gaps. A gap of zero gives long unbroken runs.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        t_char_item it;
        if (!rst_n) begin
            char_if.valid <= 1'b0;
        end else if (!char_if.valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left      <= gap_left - 1;
                char_if.valid <= 1'b0;
            end else if (char_queue.size() != 0) begin
                it = char_queue.pop_front();
                char_if.valid     <= 1'b1;
                char_if.ch        <= it.ch;
                char_if.line_end  <= it.line_end;
                char_if.conv_mode <= it.mode;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                char_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: its own stall pattern, switching between always ready, half
    // ready and mostly stalled, and forced low during the long hold-off.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 2);
            rx_left  <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            0:       num_if.ready <= (hold_left == 0);
            1:       num_if.ready <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
            default: num_if.ready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
        endcase
    end

    // Once enough items have gone in, and plenty are still waiting, the
    // receiver holds off for a long stretch while the sender keeps offering,
    // so the block fills and has to stall its input.
    always @(negedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_items >= HOLD_AFTER &&
                     char_queue.size() > HOLD_BACKLOG) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge, checks a result leaving the block against
    // the oldest prediction, then runs any character going in through the
    // predictor. A result can never belong to an item taken at the same edge.
    // ------------------------------------------------------------------------
    task automatic note_error(input string what, input t_result want,
                              input t_result got);
        error_count++;
        if (error_count <= 10)
            $display("%0t %s: expected value %h empty %b dropped %b, got value %h empty %b dropped %b",
                     $realtime, what, want.value, want.field_empty, want.chars_dropped,
                     got.value, got.field_empty, got.chars_dropped);
    endtask

    always @(posedge clk) begin
        t_result    got;
        t_result    want;
        t_char_item seen;
        bit         closes;
        in_taken = 1'b0;
        if (rst_n) begin
            if (num_if.valid && num_if.ready) begin
                got.value         = num_if.value;
                got.field_empty   = num_if.field_empty;
                got.chars_dropped = num_if.chars_dropped;
                if (field_results_q.size() == 0) begin
                    note_error("result with no field pending", '0, got);
                end else begin
                    want = field_results_q.pop_front();
                    if (got.value !== want.value || got.field_empty !== want.field_empty ||
                        got.chars_dropped !== want.chars_dropped)
                        note_error("field result mismatch", want, got);
                end
            end
            if (char_if.valid && char_if.ready) begin
                in_taken = 1'b1;
                accepted_items++;
                seen.ch       = char_if.ch;
                seen.line_end = char_if.line_end;
                seen.mode     = t_mode'(char_if.conv_mode);
                parse_char(seen, closes, want);
                if (closes)
                    field_results_q.push_back(want);
            end
        end
    end

    // Watchdog: a generous cycle budget for the slowest legal run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    logic [CH_W-1:0] delim_plan[7];

    initial begin
        // Every input is known from time zero, and reset is held low first.
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        char_if.valid     = 1'b0;
        char_if.ch        = '0;
        char_if.line_end  = 1'b0;
        char_if.conv_mode = '0;
        num_if.ready      = 1'b0;
        delim_q           = DELIM_RESET;
        clear_field();

        // Delimiters for later phases: both extremes of the register, a NUL
        // that collides with the end-of-text rule, tab and space that collide
        // with blank skipping, a digit that splits numbers, and a comma again.
        delim_plan = '{16'hFFFF, 16'h0000, CH_TAB, 16'h003B, CH_ZERO + 16'd5,
                       CH_SPACE, DELIM_RESET};

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed items with the comma that reset leaves in place.
        // Leading tab skipped, minus sign, one digit, comma.
        push_char(CH_TAB, 1'b0, MODE_DEC_SHORT);
        push_char(CH_MINUS, 1'b0, MODE_DEC_SHORT);
        push_char(CH_ZERO + 16'd7, 1'b0, MODE_DEC_SHORT);
        push_char(DELIM_RESET, 1'b0, MODE_DEC_SHORT);
        // Empty field whose closing comma is also the last character.
        push_char(DELIM_RESET, 1'b1, MODE_DEC_SHORT);
        // Hex: an upper-case letter, a letter past f that counts as zero, and
        // a digit marked as the end of the line.
        push_char(CH_UPPER_F, 1'b0, MODE_HEX);
        push_char(CH_LOWER_F + 16'd1, 1'b0, MODE_HEX);
        push_char(CH_ZERO, 1'b1, MODE_HEX);
        // Address: the largest decimal part, nibble F, then the top code.
        push_char(CH_NINE, 1'b0, MODE_ADDR);
        push_char(CH_NINE, 1'b0, MODE_ADDR);
        push_char(CH_NINE, 1'b0, MODE_ADDR);
        push_char(CH_UPPER_F, 1'b0, MODE_ADDR);
        push_char(16'hFFFF, 1'b1, MODE_ADDR);
        // NUL as the first kept character, long decimal mode.
        push_char(CH_NUL, 1'b1, MODE_DEC_LONG);
        // Over-long field: nine digits kept, the tenth discarded, then CR.
        for (int i = 0; i < DEF_SHORT_KEEP; i++)
            push_char(CH_ZERO + 16'd1, 1'b0, MODE_DEC_SHORT);
        push_char(CH_ZERO + 16'd2, 1'b0, MODE_DEC_SHORT);
        push_char(CH_CR, 1'b0, MODE_DEC_SHORT);

        queue_random_phase();

        foreach (delim_plan[p]) begin
            wait_idle();
            write_delimiter(delim_plan[p]);
            queue_random_phase();
        end

        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
